// ===== hw/rtl/mme_pkg.sv =====
package mme_pkg;

    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 3;
    localparam int VALUE_W  = 32;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W  = 40;

    // action codes carried in s_tuser
    localparam logic [ACTION_W-1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

    typedef struct packed {
        logic               wr_a;
        logic               wr_b;
        logic               issue;
        logic               first;
        logic               last_k;
        logic               emit;
        logic [INDEX_W-1:0] emit_row;
        logic [INDEX_W-1:0] emit_col;
        logic               emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic fin_valid;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/mme_ctrl.sv =====
module mme_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mme_pkg::ACTION_W-1:0]  action,
    input  logic [mme_pkg::INDEX_W-1:0]   elem_row,
    input  logic [mme_pkg::INDEX_W-1:0]   elem_col,
    input  logic                          cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]     cfg_data,
    input  mme_pkg::dp_status_t           status,
    output mme_pkg::dp_cmd_t              cmd,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr_a,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr_b
);

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [DW-1:0] m_reg, m_next, n_reg, n_next, o_reg, o_next;
    logic [mme_pkg::CFG_W-1:0] rows_a_reg, rows_a_next;
    logic [mme_pkg::CFG_W-1:0] inner_dim_reg, inner_dim_next;
    logic [mme_pkg::CFG_W-1:0] cols_b_reg, cols_b_next;

    logic accept, in_range, i_last, j_last, k_last;

    function automatic logic [DW-1:0] eff_dim(input logic [mme_pkg::CFG_W-1:0] d);
        logic [DW-1:0] r;
        if (d == '0)
            r = DW'(1);
        else if (int'(d) > MAX_DIM)
            r = DW'(MAX_DIM);
        else
            r = DW'(d);
        return r;
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_range = (int'(elem_row) < MAX_DIM) && (int'(elem_col) < MAX_DIM);
    assign i_last   = (DW'(i_reg) + DW'(1) == m_reg);
    assign j_last   = (DW'(j_reg) + DW'(1) == o_reg);
    assign k_last   = (DW'(k_reg) + DW'(1) == n_reg);

    assign wr_addr   = AW'(int'(elem_row) * MAX_DIM + int'(elem_col));
    assign rd_addr_a = AW'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign rd_addr_b = AW'(int'(k_reg) * MAX_DIM + int'(j_reg));

    always_comb
    begin
        cmd.wr_a      = accept && (action == mme_pkg::ACT_LOAD_A) && in_range;
        cmd.wr_b      = accept && (action == mme_pkg::ACT_LOAD_B) && in_range;
        cmd.issue     = (state_reg == ST_ISSUE);
        cmd.first     = (k_reg == '0);
        cmd.last_k    = k_last;
        cmd.emit      = (state_reg == ST_EMIT) && status.out_free;
        cmd.emit_row  = mme_pkg::INDEX_W'(i_reg);
        cmd.emit_col  = mme_pkg::INDEX_W'(j_reg);
        cmd.emit_last = i_last && j_last;
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        o_next         = o_reg;
        rows_a_next    = rows_a_reg;
        inner_dim_next = inner_dim_reg;
        cols_b_next    = cols_b_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                mme_pkg::CFG_ROWS_A:    rows_a_next    = cfg_data;
                mme_pkg::CFG_INNER_DIM: inner_dim_next = cfg_data;
                mme_pkg::CFG_COLS_B:    cols_b_next    = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == mme_pkg::ACT_COMPUTE))
                begin
                    // latch clamped dimensions for the whole product
                    m_next     = eff_dim(rows_a_reg);
                    n_next     = eff_dim(inner_dim_reg);
                    o_next     = eff_dim(cols_b_reg);
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (k_last)
                    state_next = ST_WAIT;
                else
                    k_next = k_reg + CW'(1);
            end
            ST_WAIT:
            begin
                if (status.fin_valid)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    if (i_last && j_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        k_next = '0;
                        if (j_last)
                        begin
                            j_next = '0;
                            i_next = i_reg + CW'(1);
                        end
                        else
                            j_next = j_reg + CW'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            m_reg         <= DW'(1);
            n_reg         <= DW'(1);
            o_reg         <= DW'(1);
            rows_a_reg    <= mme_pkg::CFG_DIM_RESET;
            inner_dim_reg <= mme_pkg::CFG_DIM_RESET;
            cols_b_reg    <= mme_pkg::CFG_DIM_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            m_reg         <= m_next;
            n_reg         <= n_next;
            o_reg         <= o_next;
            rows_a_reg    <= rows_a_next;
            inner_dim_reg <= inner_dim_next;
            cols_b_reg    <= cols_b_next;
        end
    end

endmodule

// ===== hw/rtl/mme_datapath.sv =====
module mme_datapath #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mme_pkg::dp_cmd_t                    cmd,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  wr_addr,
    input  logic [mme_pkg::VALUE_W-1:0]         wr_data,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  rd_addr_a,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  rd_addr_b,
    output mme_pkg::dp_status_t                 status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [mme_pkg::INDEX_W-1:0]         out_row,
    output logic [mme_pkg::INDEX_W-1:0]         out_col,
    output logic [mme_pkg::VALUE_W-1:0]         out_value,
    output logic                                out_sat,
    output logic                                out_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int PW    = 2 * mme_pkg::VALUE_W;
    localparam int ACC_W = PW + 1 + $clog2(MAX_DIM);
    localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'($signed(32'h7fff_ffff));
    localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'($signed(32'h8000_0000));

    logic [mme_pkg::VALUE_W-1:0] a_mem [DEPTH];
    logic [mme_pkg::VALUE_W-1:0] b_mem [DEPTH];

    logic signed [mme_pkg::VALUE_W-1:0] a_rd_reg, b_rd_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [PW-1:0]    prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] shifted;
    logic [mme_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    logic res_sat_reg, res_sat_next;

    logic rd_vld_reg, rd_first_reg, rd_last_reg;
    logic pr_vld_reg, pr_first_reg, pr_last_reg;
    logic acc_done_reg, fin_valid_reg;
    logic out_valid_reg;
    logic [mme_pkg::INDEX_W-1:0] out_row_reg, out_col_reg;
    logic [mme_pkg::VALUE_W-1:0] out_value_reg;
    logic out_sat_reg, out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
            a_mem[wr_addr] <= wr_data;
        if (cmd.wr_b)
            b_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            a_rd_reg <= a_mem[rd_addr_a];
            b_rd_reg <= b_mem[rd_addr_b];
        end
    end

    assign prod_next = a_rd_reg * b_rd_reg;
    assign acc_next  = pr_first_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
    assign shifted   = acc_reg >>> FRAC_BITS;

    always_comb
    begin
        if (shifted > Q_MAX)
        begin
            res_value_next = 32'h7fff_ffff;
            res_sat_next   = 1'b1;
        end
        else if (shifted < Q_MIN)
        begin
            res_value_next = 32'h8000_0000;
            res_sat_next   = 1'b1;
        end
        else
        begin
            res_value_next = shifted[mme_pkg::VALUE_W-1:0];
            res_sat_next   = 1'b0;
        end
    end

    // payload stages: product, accumulate, saturate, output
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
            prod_reg <= prod_next;
        if (pr_vld_reg)
            acc_reg <= acc_next;
        if (acc_done_reg)
        begin
            res_value_reg <= res_value_next;
            res_sat_reg   <= res_sat_next;
        end
        if (cmd.emit)
        begin
            out_row_reg   <= cmd.emit_row;
            out_col_reg   <= cmd.emit_col;
            out_value_reg <= res_value_reg;
            out_sat_reg   <= res_sat_reg;
            out_last_reg  <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            pr_vld_reg    <= 1'b0;
            pr_first_reg  <= 1'b0;
            pr_last_reg   <= 1'b0;
            acc_done_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg    <= cmd.issue;
            rd_first_reg  <= cmd.first;
            rd_last_reg   <= cmd.last_k;
            pr_vld_reg    <= rd_vld_reg;
            pr_first_reg  <= rd_first_reg;
            pr_last_reg   <= rd_last_reg;
            acc_done_reg  <= pr_vld_reg && pr_last_reg;
            fin_valid_reg <= acc_done_reg;
            // hold the beat until taken
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.fin_valid = fin_valid_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_sat   = out_sat_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hw/rtl/matrix_multiply_engine_top.sv =====
// channel   dir   handshake          payload
// s_*       in    s_tvalid/s_tready  tdata: row, col, value; tuser: action
// m_*       out   m_tvalid/m_tready  tdata: row, col, value; tuser: saturated; tlast
// cfg_*     in    cfg_we             cfg_index, cfg_data (no read-back)
//
// A load is written into its store when accepted. For an M by N times N by P
// product, each result element walks N terms through the shared read, multiply
// and accumulate pipe, then drains four stages and is emitted.
// The element stores have one read port each, which sets the N-term walk.
// Reset clears control and sets each dimension to 8; stores are not cleared.
// A stalled m_tready holds the result register and freezes the walk.
module matrix_multiply_engine_top #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mme_pkg::TDATA_W-1:0]    s_tdata,   // elem_row, elem_col, elem_value
    input  logic [mme_pkg::ACTION_W-1:0]   s_tuser,   // action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mme_pkg::TDATA_W-1:0]    m_tdata,   // out_row, out_col, product_value
    output logic                           m_tuser,   // saturated
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]      cfg_data
);

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int PAD_W = mme_pkg::TDATA_W - 2 * mme_pkg::INDEX_W - mme_pkg::VALUE_W;

    mme_pkg::dp_cmd_t    cmd;
    mme_pkg::dp_status_t status;
    logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic [mme_pkg::INDEX_W-1:0] elem_row, elem_col, out_row, out_col;
    logic [mme_pkg::VALUE_W-1:0] elem_value, out_value;

    assign elem_row   = s_tdata[mme_pkg::INDEX_W-1:0];
    assign elem_col   = s_tdata[2*mme_pkg::INDEX_W-1:mme_pkg::INDEX_W];
    assign elem_value = s_tdata[2*mme_pkg::INDEX_W+mme_pkg::VALUE_W-1:2*mme_pkg::INDEX_W];

    mme_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .action    (s_tuser),
        .elem_row  (elem_row),
        .elem_col  (elem_col),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b)
    );

    mme_datapath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .wr_data   (elem_value),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_sat   (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_value, out_col, out_row};

endmodule
